[sv/tct_pkg.sv]
// Shared types and constants of the TCP connection tracker.
`default_nettype none

package tct_pkg;

  // Number of tracked (ip, port) pairs; valid from 2 to 256
  localparam int TABLE_DEPTH = 16;

  localparam int IP_W    = 32;
  localparam int PORT_W  = 16;
  localparam int CLASS_W = 2;

  // Packet classification codes
  typedef enum logic [CLASS_W-1:0] {
    CLASS_CONNECT     = 2'd0,
    CLASS_DISCONNECT  = 2'd1,
    CLASS_ESTABLISHED = 2'd2
  } pkt_class_t;

  // One packet header as held in the input register
  typedef struct packed {
    logic [IP_W-1:0]   source_ip;
    logic [PORT_W-1:0] source_port;
    logic [IP_W-1:0]   dest_ip;
    logic [PORT_W-1:0] dest_port;
    logic              flag_syn;
    logic              flag_ack;
    logic              flag_rst;
  } pkt_t;

endpackage

`default_nettype wire

[sv/tct_pkt_if.sv]
// Packet channel interface: one TCP header per transaction.
`default_nettype none

interface tct_pkt_if;
  import tct_pkg::*;

  logic              valid;
  logic              ready;
  logic [IP_W-1:0]   source_ip;
  logic [PORT_W-1:0] source_port;
  logic [IP_W-1:0]   dest_ip;
  logic [PORT_W-1:0] dest_port;
  logic              flag_syn;
  logic              flag_ack;
  logic              flag_rst;

  modport source (
    output valid, source_ip, source_port, dest_ip, dest_port,
           flag_syn, flag_ack, flag_rst,
    input  ready
  );

  modport sink (
    input  valid, source_ip, source_port, dest_ip, dest_port,
           flag_syn, flag_ack, flag_rst,
    output ready
  );
endinterface

`default_nettype wire

[sv/tct_res_if.sv]
// Result channel interface: one classification verdict per transaction.
`default_nettype none

interface tct_res_if;
  import tct_pkg::*;

  logic       valid;
  logic       ready;
  logic       redirected;
  pkt_class_t packet_class;
  logic       table_full;

  modport source (
    output valid, redirected, packet_class, table_full,
    input  ready
  );

  modport sink (
    input  valid, redirected, packet_class, table_full,
    output ready
  );
endinterface

`default_nettype wire

[sv/tcp_connection_tracker_core.sv]
// Top level of the TCP connection tracker: classifier plus (ip, port) table.
//
// in_chan carries one TCP header per transaction (addresses, ports and the
// SYN, ACK and RST flags). out_chan returns exactly one verdict for each:
// redirected, packet_class (connect, disconnect, established) and table_full.
// A connect stores its source pair in the lowest free slot unless already
// tracked; other packets look up the source pair, then the destination pair,
// and a disconnect frees the slot that hit.
// A header accepted into the input register has its result registered and
// offered on out_chan once it moves on. Throughput: one header per cycle while
// out_chan is not stalled, set by the single processing stage that compares the
// held header against every slot in parallel and updates the table at the same
// edge, so each header sees the table exactly as the previous one left it.
// Reset (rst_n low, synchronous) empties both stages and marks every slot
// free; it needs no clearing pass.
// When out_chan stalls, the pending result holds; one more header is taken
// into the input register, after which in_chan.ready drops until the result
// is taken.
`default_nettype none

module tcp_connection_tracker_core (
  input  logic     clk,
  input  logic     rst_n,
  tct_pkt_if.sink  in_chan,
  tct_res_if.source out_chan
);
  import tct_pkg::*;

  // Input register
  logic s1_vld_r;
  pkt_t s1_r;

  // Result register
  logic       out_vld_r;
  logic       redir_r;
  pkt_class_t cls_r;
  logic       full_r;

  // Connection table
  logic [TABLE_DEPTH-1:0] slot_valid_r;
  logic [TABLE_DEPTH-1:0] slot_valid_nxt;
  logic [IP_W-1:0]        slot_ip_r   [TABLE_DEPTH];
  logic [PORT_W-1:0]      slot_port_r [TABLE_DEPTH];

  logic                   adv;
  pkt_class_t             cls;
  logic [TABLE_DEPTH-1:0] src_match;
  logic [TABLE_DEPTH-1:0] dst_match;
  logic                   src_hit;
  logic                   dst_hit;
  logic [TABLE_DEPTH-1:0] free_vec;
  logic [TABLE_DEPTH-1:0] free_pick;
  logic                   any_free;
  logic [TABLE_DEPTH-1:0] set_vec;
  logic [TABLE_DEPTH-1:0] clr_vec;
  logic                   redir;
  logic                   full;

  // Handshake: the held header moves on when the result register is free
  assign adv           = s1_vld_r && (!out_vld_r || out_chan.ready);
  assign in_chan.ready = !s1_vld_r || adv;

  assign out_chan.valid        = out_vld_r;
  assign out_chan.redirected   = redir_r;
  assign out_chan.packet_class = cls_r;
  assign out_chan.table_full   = full_r;

  // Classify: SYN without ACK wins over RST
  always_comb begin
    priority if (s1_r.flag_syn && !s1_r.flag_ack) begin
      cls = CLASS_CONNECT;
    end else if (s1_r.flag_rst) begin
      cls = CLASS_DISCONNECT;
    end else begin
      cls = CLASS_ESTABLISHED;
    end
  end

  // Parallel match of both pairs against every valid slot
  always_comb begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      src_match[i] = slot_valid_r[i] && (slot_ip_r[i] == s1_r.source_ip)
                     && (slot_port_r[i] == s1_r.source_port);
      dst_match[i] = slot_valid_r[i] && (slot_ip_r[i] == s1_r.dest_ip)
                     && (slot_port_r[i] == s1_r.dest_port);
    end
  end

  assign src_hit = |src_match;
  assign dst_hit = |dst_match;

  // Lowest free slot as a one-hot vector (isolate lowest set bit)
  assign free_vec  = ~slot_valid_r;
  assign free_pick = free_vec & ((~free_vec) + {{(TABLE_DEPTH-1){1'b0}}, 1'b1});
  assign any_free  = |free_vec;

  // Table update and verdict
  always_comb begin
    set_vec = '0;
    clr_vec = '0;
    redir   = 1'b0;
    full    = 1'b0;
    unique case (cls)
      CLASS_CONNECT: begin
        redir = 1'b1;
        if (!src_hit) begin
          if (any_free) begin
            set_vec = free_pick;
          end else begin
            full = 1'b1;
          end
        end
      end
      CLASS_DISCONNECT: begin
        redir   = src_hit || dst_hit;
        // a pair is stored at most once, so the match vector has at most one bit set
        clr_vec = src_hit ? src_match : dst_match;
      end
      default: begin
        redir = src_hit || dst_hit;
      end
    endcase
  end

  assign slot_valid_nxt = (slot_valid_r & ~clr_vec) | set_vec;

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r     <= 1'b0;
      out_vld_r    <= 1'b0;
      slot_valid_r <= '0;
    end else begin
      if (in_chan.ready) begin
        s1_vld_r <= in_chan.valid;
      end
      if (adv) begin
        slot_valid_r <= slot_valid_nxt;
        out_vld_r    <= 1'b1;
      end else if (out_chan.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // Payload: header capture, result capture, slot writes
  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      s1_r.source_ip   <= in_chan.source_ip;
      s1_r.source_port <= in_chan.source_port;
      s1_r.dest_ip     <= in_chan.dest_ip;
      s1_r.dest_port   <= in_chan.dest_port;
      s1_r.flag_syn    <= in_chan.flag_syn;
      s1_r.flag_ack    <= in_chan.flag_ack;
      s1_r.flag_rst    <= in_chan.flag_rst;
    end
    if (adv) begin
      redir_r <= redir;
      cls_r   <= cls;
      full_r  <= full;
    end
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (adv && set_vec[i]) begin
        slot_ip_r[i]   <= s1_r.source_ip;
        slot_port_r[i] <= s1_r.source_port;
      end
    end
  end

endmodule

`default_nettype wire

[sv/tct_checker.sv]
// Port-level checks on the tracker's result channel, bound to the top level.
`default_nettype none

module tct_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        out_redirected,
  input logic [tct_pkg::CLASS_W-1:0] out_packet_class,
  input logic                        out_table_full
);
  import tct_pkg::*;

  // A stalled result holds its contents
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_redirected)
      && $stable(out_packet_class) && $stable(out_table_full))
    else $error("result changed while stalled");

  // Only a connect can report a full table, and it is still redirected
  a_full_connect: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_table_full |->
      (out_packet_class == CLASS_CONNECT) && out_redirected)
    else $error("table_full on a packet that is not a redirected connect");

  // Every connect is redirected
  a_connect_redir: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_packet_class == CLASS_CONNECT) |-> out_redirected)
    else $error("connect not redirected");

  // Reset empties the result stage
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind tcp_connection_tracker_core tct_checker u_tct_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_chan.valid),
  .out_ready        (out_chan.ready),
  .out_redirected   (out_chan.redirected),
  .out_packet_class (out_chan.packet_class),
  .out_table_full   (out_chan.table_full)
);

`default_nettype wire
